### src/sorted_table_equal_range_search_macros.svh
// Assertion macros for the sorted-table equal-range search block.
// Included by the top level; depends on nothing else.
`ifndef SORTED_TABLE_EQUAL_RANGE_SEARCH_MACROS_SVH
`define SORTED_TABLE_EQUAL_RANGE_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STSR_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STSR_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/stsr_pkg.sv
// Shared types and constants of the sorted-table equal-range search block.
// Used by the search engine and the top level; depends on nothing else.
package stsr_pkg;

    localparam int COUNT_W = 11;
    localparam int POS_W   = 10;
    localparam int VALUE_W = 32;
    // Search bounds run from -1 up to the entry count, as signed values.
    localparam int BOUND_W = COUNT_W + 1;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_ELEMENT_COUNT = 1'b0;

    typedef struct packed {
        logic                      mode;
        logic [POS_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] first_pos;
        logic [POS_W-1:0] last_pos;
    } rsp_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOW,
        ST_HIGH,
        ST_DONE
    } eng_state_t;

endpackage

### src/stsr_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing else.
module stsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/stsr_engine.sv
// Search engine: two binary searches over the table memory, one probe a cycle.
// Depends on stsr_pkg.
module stsr_engine #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [stsr_pkg::VALUE_W-1:0] key,
    input  logic [stsr_pkg::COUNT_W-1:0]        count,
    input  logic [stsr_pkg::VALUE_W-1:0]        rdata,
    input  logic                                take,
    output logic                                rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
    output stsr_pkg::eng_status_t               status,
    output stsr_pkg::rsp_item_t                 result
);

    import stsr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    eng_state_t state_reg, state_next;

    logic                       pend_reg, pend_next;
    logic signed [VALUE_W-1:0]  key_reg, key_next;
    logic signed [BOUND_W-1:0]  n_reg, n_next;
    logic signed [BOUND_W-1:0]  lo_reg, lo_next;
    logic signed [BOUND_W-1:0]  hi_reg, hi_next;
    logic signed [BOUND_W-1:0]  mid_reg, mid_next;
    logic                       hit_reg, hit_next;
    logic signed [BOUND_W-1:0]  first_reg, first_next;
    logic                       hitf_reg, hitf_next;
    logic signed [BOUND_W-1:0]  last_reg, last_next;
    logic                       hitl_reg, hitl_next;

    logic signed [VALUE_W-1:0]  probe;
    logic                       go_low;
    logic                       probe_eq;
    logic signed [BOUND_W-1:0]  lo_step, hi_step, mid_step;
    logic                       hit_step;
    logic signed [BOUND_W:0]    span;
    logic signed [BOUND_W:0]    bsum;
    logic                       more;
    logic signed [BOUND_W-1:0]  n_sat;

    // The count register is limited to the table depth for searching.
    assign n_sat = ((32'(count) > TABLE_DEPTH) ? BOUND_W'(TABLE_DEPTH)
                                               : BOUND_W'(count));

    assign probe    = $signed(rdata);
    assign probe_eq = (probe == key_reg);
    assign go_low   = (state_reg == ST_LOW) ? (probe < key_reg) : (probe <= key_reg);

    // Fold in the probe that returned this cycle, then pick the next midpoint.
    always_comb
    begin
        lo_step  = lo_reg;
        hi_step  = hi_reg;
        hit_step = hit_reg;
        if (pend_reg)
        begin
            if (go_low)
            begin
                lo_step = mid_reg;
                if (state_reg == ST_HIGH)
                begin
                    hit_step = probe_eq;
                end
            end
            else
            begin
                hi_step = mid_reg;
                if (state_reg == ST_LOW)
                begin
                    hit_step = probe_eq;
                end
            end
        end
        span     = {hi_step[BOUND_W-1], hi_step} - {lo_step[BOUND_W-1], lo_step};
        more     = (span > (BOUND_W+1)'(1));
        bsum     = {hi_step[BOUND_W-1], hi_step} + {lo_step[BOUND_W-1], lo_step};
        mid_step = bsum[BOUND_W:1];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOW;
                end
            end
            ST_LOW:
            begin
                if (!more)
                begin
                    state_next = ST_HIGH;
                end
            end
            ST_HIGH:
            begin
                if (!more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_next  = 1'b0;
        key_next   = key_reg;
        n_next     = n_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        hit_next   = hit_reg;
        first_next = first_reg;
        hitf_next  = hitf_reg;
        last_next  = last_reg;
        hitl_next  = hitl_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                key_next = key;
                n_next   = n_sat;
                lo_next  = -BOUND_W'(1);
                hi_next  = n_sat;
                hit_next = 1'b0;
            end
            ST_LOW, ST_HIGH:
            begin
                lo_next   = lo_step;
                hi_next   = hi_step;
                hit_next  = hit_step;
                mid_next  = mid_step;
                pend_next = more;
                if (!more)
                begin
                    if (state_reg == ST_LOW)
                    begin
                        first_next = hi_step;
                        hitf_next  = hit_step;
                        lo_next    = -BOUND_W'(1);
                        hi_next    = n_reg;
                        hit_next   = 1'b0;
                    end
                    else
                    begin
                        last_next = lo_step;
                        hitl_next = hit_step;
                    end
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rd_en         = ((state_reg == ST_LOW) || (state_reg == ST_HIGH)) && more;
        rd_addr       = AW'($unsigned(mid_step));
        status.busy   = (state_reg != ST_IDLE);
        status.done   = (state_reg == ST_DONE);
        result.found  = hitf_reg;
        result.first_pos = hitf_reg ? POS_W'($unsigned(first_reg)) : '0;
        result.last_pos  = (hitf_reg && hitl_reg) ? POS_W'($unsigned(last_reg)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        n_reg     <= n_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        hit_reg   <= hit_next;
        first_reg <= first_next;
        hitf_reg  <= hitf_next;
        last_reg  <= last_next;
        hitl_reg  <= hitl_next;
    end

endmodule

### src/sorted_table_equal_range_search.sv
// Top level of the sorted-table equal-range search block.
// Depends on stsr_pkg, stsr_ram, stsr_engine and the assertion macro header.
//
// Usage. The request channel (req_valid, req_stall, req) carries one transaction
// per item. A load transaction (mode 0) writes req.value into table entry
// req.index in the cycle it is accepted and gives no response; an index at or
// beyond TABLE_DEPTH is dropped. A query transaction (mode 1) uses req.value as
// the key and runs two binary searches over the first element_count entries:
// the first finds the lowest entry not below the key, the second the highest
// entry not above it. One response transaction (rsp_valid, rsp_stall, rsp) then
// reports found, first_pos and last_pos; both positions are zero on a miss.
// A query holds req_stall high while it runs, with one table memory read per
// probe; the next request is taken once its result has gone to the output register.
// The response sits in an output register; a stalled response does not block
// loads, and the next query runs up to its last cycle before waiting on it.
// Reset clears element_count and all control state. Table entries are not
// cleared and must be loaded before any query reaches them.
// element_count is written through the APB port at address 0. The user must
// write it only while idle; the block itself does not enforce this.
module sorted_table_equal_range_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  stsr_pkg::req_item_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output stsr_pkg::rsp_item_t           rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stsr_pkg::PADDR_W-1:0]  paddr,
    input  logic [stsr_pkg::PDATA_W-1:0]  pwdata,
    output logic [stsr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import stsr_pkg::*;

    `include "sorted_table_equal_range_search_macros.svh"

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_reg, rsp_next;

    logic               req_accept;
    logic               load_we;
    logic               query_start;
    logic               take;
    logic               eng_rd_en;
    logic [AW-1:0]      eng_rd_addr;
    logic [AW-1:0]      ram_addr;
    logic [VALUE_W-1:0] ram_rdata;
    eng_status_t        eng_status;
    rsp_item_t          eng_result;

    // Configuration port: one register, no wait states.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? PDATA_W'(count_reg) : '0;

    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT))
        begin
            count_next = pwdata[COUNT_W-1:0];
        end
    end

    // The request side is held off only while a query is in the engine.
    assign req_stall   = eng_status.busy;
    assign req_accept  = req_valid && !req_stall;
    assign load_we     = req_accept && (req.mode == MODE_LOAD)
                         && (32'(req.index) < TABLE_DEPTH);
    assign query_start = req_accept && (req.mode == MODE_QUERY);

    // Loads only happen while the engine is idle, so they never meet a probe.
    assign ram_addr = load_we ? AW'(req.index) : eng_rd_addr;

    stsr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .re    (eng_rd_en),
        .addr  (ram_addr),
        .wdata (req.value),
        .rdata (ram_rdata)
    );

    stsr_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (query_start),
        .key     (req.value),
        .count   (count_reg),
        .rdata   (ram_rdata),
        .take    (take),
        .rd_en   (eng_rd_en),
        .rd_addr (eng_rd_addr),
        .status  (eng_status),
        .result  (eng_result)
    );

    // The output register takes a finished result once it is empty or draining.
    assign take = eng_status.done && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = (rsp_valid_reg && rsp_stall) || take;
        rsp_next       = take ? eng_result : rsp_reg;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    `STSR_ASSERT_NEXT(a_query_holds_off, clk, rst_n, query_start, req_stall,
        "accepted query did not stall the request channel")

    `STSR_ASSERT_NOW(a_no_write_during_search, clk, rst_n, load_we, !eng_rd_en,
        "table write collided with a search probe")

    `STSR_ASSERT_NEXT(a_take_shows_result, clk, rst_n, take, rsp_valid && !req_stall,
        "handed-off result not shown or engine not released")

endmodule

### bench/tb_sorted_table_equal_range_search.sv
// Self-checking testbench for the sorted-table equal-range search block.
// Depends on stsr_pkg and the sorted_table_equal_range_search top level;
// it drives table loads, queries and APB writes and checks every response.
module tb_sorted_table_equal_range_search;

    import stsr_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    // Long enough to cover one full-table query still in flight.
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 30;
    localparam int TIMEOUT_CYCLES = 1000000;

    localparam logic [PADDR_W-1:0] COUNT_ADDR = {REG_ELEMENT_COUNT, 2'b00};
    // paddr[2] set selects a register index that does not exist.
    localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_ELEMENT_COUNT, 2'b00};

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam rsp_item_t NO_HIT = '0;

    // Idle patterns applied to the request and response channels.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int {
        ROW_LOAD,
        ROW_QUERY,
        ROW_WRITE
    } row_kind_t;

    // One row of the directed table. For ROW_WRITE, value is the APB data.
    // When fixed_want is set, want is the expected response of a query row;
    // otherwise the predictor supplies it.
    typedef struct {
        row_kind_t                 kind;
        logic [PADDR_W-1:0]        addr;
        logic [POS_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
        bit                        fixed_want;
        rsp_item_t                 want;
    } dir_row_t;

    localparam int NUM_ROWS = 24;

    dir_row_t directed_rows [NUM_ROWS] = '{
        // Empty table right after reset: every query misses.
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   32'sd0,        1'b1, NO_HIT},
        '{ROW_QUERY, COUNT_ADDR, 10'h3FF, VALUE_MIN,     1'b1, NO_HIT},
        // A write to the unused register index must leave the count at zero.
        '{ROW_WRITE, SPARE_ADDR, 10'd0,   32'sd5,        1'b0, NO_HIT},
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   VALUE_MAX,     1'b1, NO_HIT},
        // Five sorted entries spanning both extremes, with a duplicate pair.
        '{ROW_LOAD,  COUNT_ADDR, 10'd0,   VALUE_MIN,     1'b0, NO_HIT},
        '{ROW_LOAD,  COUNT_ADDR, 10'd1,   -32'sd5,       1'b0, NO_HIT},
        '{ROW_LOAD,  COUNT_ADDR, 10'd2,   -32'sd5,       1'b0, NO_HIT},
        '{ROW_LOAD,  COUNT_ADDR, 10'd3,   32'sd7,        1'b0, NO_HIT},
        '{ROW_LOAD,  COUNT_ADDR, 10'd4,   VALUE_MAX,     1'b0, NO_HIT},
        // Upper data bits are outside the register and must be dropped.
        '{ROW_WRITE, COUNT_ADDR, 10'd0,   32'shFFFF_F805, 1'b0, NO_HIT},
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   VALUE_MIN,     1'b1, '{1'b1, 10'd0, 10'd0}},
        '{ROW_QUERY, COUNT_ADDR, 10'h3FF, VALUE_MAX,     1'b1, '{1'b1, 10'd4, 10'd4}},
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   -32'sd5,       1'b0, NO_HIT},
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   32'sd0,        1'b0, NO_HIT},
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   32'sd8,        1'b0, NO_HIT},
        // Highest table index, outside the searched range.
        '{ROW_LOAD,  COUNT_ADDR, 10'h3FF, 32'sh5555_AAAA, 1'b0, NO_HIT},
        // Single-entry table.
        '{ROW_WRITE, COUNT_ADDR, 10'd0,   32'sd1,        1'b0, NO_HIT},
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   VALUE_MIN,     1'b1, '{1'b1, 10'd0, 10'd0}},
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   -32'sd5,       1'b0, NO_HIT},
        // Break the order: the searches must still follow their probe path.
        '{ROW_LOAD,  COUNT_ADDR, 10'd2,   -32'sd100,     1'b0, NO_HIT},
        '{ROW_WRITE, COUNT_ADDR, 10'd0,   32'sd5,        1'b0, NO_HIT},
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   -32'sd100,     1'b0, NO_HIT},
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   32'sd7,        1'b0, NO_HIT},
        '{ROW_QUERY, COUNT_ADDR, 10'd0,   -32'sd5,       1'b0, NO_HIT}
    };

    // Clock, reset and DUT-facing signals. Every input starts at a known value.
    logic               clk;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_item_t          req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_item_t          rsp;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Predictor state: a mirror of the table and of the element_count register.
    logic signed [VALUE_W-1:0] entry_mirror [DEPTH];
    logic [COUNT_W-1:0]        count_mirror = '0;

    // Expected responses, oldest first, one per accepted query.
    rsp_item_t pending_ranges [$];

    int mismatch_count = 0;
    int req_gap_pct    = 0;
    int rsp_stall_pct  = 0;
    int rsp_hold_left  = 0;

    sorted_table_equal_range_search #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit, far above the slowest legal run of this stimulus.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

    // Equal-range prediction. Both searches start with bounds -1 and n and
    // halve the interval exactly as the hardware does, so an unsorted table
    // gives the same answer as long as the probe path is followed.
    function automatic rsp_item_t predict_range(logic signed [VALUE_W-1:0] key);
        int        n;
        int        lo;
        int        hi;
        int        mid;
        int        first_idx;
        int        last_idx;
        rsp_item_t result;
        n = (count_mirror > DEPTH) ? DEPTH : int'(count_mirror);
        lo = -1;
        hi = n;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (entry_mirror[mid] < key)
                lo = mid;
            else
                hi = mid;
        end
        first_idx = hi;
        lo = -1;
        hi = n;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (entry_mirror[mid] <= key)
                lo = mid;
            else
                hi = mid;
        end
        last_idx = lo;
        result = NO_HIT;
        // Hit and first position come from the lower search alone; the upper
        // position is only reported when that search also lands on the key.
        if (first_idx < n && entry_mirror[first_idx] == key)
        begin
            result.found     = 1'b1;
            result.first_pos = POS_W'(first_idx);
            if (last_idx >= 0 && entry_mirror[last_idx] == key)
                result.last_pos = POS_W'(last_idx);
        end
        return result;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offers one transaction on the request channel and returns at the edge
    // where it is accepted. The mirror and the expectation queue are updated
    // at that edge, so they follow acceptance order. valid stays high after
    // acceptance; drain_responses lowers it at the end of a batch.
    task automatic send_item(input req_item_t item, input bit fixed_want,
                             input rsp_item_t want);
        while ($urandom_range(1, 100) <= req_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (item.mode == MODE_LOAD)
            entry_mirror[item.index] = item.value;
        else if (fixed_want)
            pending_ranges.push_back(want);
        else
            pending_ranges.push_back(predict_range(item.value));
    endtask

    // Stops the request channel and waits until the block has gone quiet,
    // which is the only time the configuration register is touched.
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup phase, access phase, then an idle phase with psel
    // low, so that back-to-back transfers never assign psel twice in one step.
    task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes a register and reads element_count back to confirm its value.
    task automatic write_register(input logic [PADDR_W-1:0] addr,
                                  input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] readback;
        apb_access(1'b1, addr, data, readback);
        if (addr[2] == REG_ELEMENT_COUNT)
            count_mirror = data[COUNT_W-1:0];
        apb_access(1'b0, COUNT_ADDR, '0, readback);
        check_field("element_count readback", 32'(count_mirror), 32'(readback[COUNT_W-1:0]));
    endtask

    // Response side: checks each accepted transaction against the oldest
    // expectation and decides the stall for the next cycle. A long hold,
    // once requested, is counted down here before random stalling resumes.
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_ranges.size() == 0)
            begin
                $display("%0t: response with no query pending, expected none, got %0d/%0d/%0d",
                         $time, rsp.found, rsp.first_pos, rsp.last_pos);
                mismatch_count++;
            end
            else
            begin
                want = pending_ranges.pop_front();
                check_field("found", 32'(want.found), 32'(rsp.found));
                check_field("first_pos", 32'(want.first_pos), 32'(rsp.first_pos));
                check_field("last_pos", 32'(want.last_pos), 32'(rsp.last_pos));
            end
        end
        if (rsp_hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
        end
        else
        begin
            rsp_stall <= ($urandom_range(1, 100) <= rsp_stall_pct);
        end
    end

    initial
    begin
        req_item_t          item;
        dir_row_t           row;
        idle_mode_t         idle_mode;
        int                 phase_counts [NUM_PHASES];
        int                 count;
        int                 n_eff;
        int                 idx;
        int                 pick;
        int                 i;
        longint             running;
        longint             left;
        longint             right;
        longint unsigned    wide_rand;
        logic [PDATA_W-1:0] wdata;

        // Fixed sizes first (table depth, register maximum, edge cases); negative
        // entries are drawn at random when the phase starts.
        phase_counts = '{1024, 2047, 1, 1025, 0, 2, -1, -1, -1, -1};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Writes wait for the block to drain; loads and
        // queries go straight onto the request channel.
        req_gap_pct   = 21;
        rsp_stall_pct = 21;
        for (i = 0; i < NUM_ROWS; i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                drain_responses();
                write_register(row.addr, row.value);
            end
            else
            begin
                item.mode  = (row.kind == ROW_LOAD) ? MODE_LOAD : MODE_QUERY;
                item.index = row.index;
                item.value = row.value;
                send_item(item, row.fixed_want, row.want);
            end
        end
        drain_responses();

        // Load the whole table in non-decreasing order, starting at or just above
        // the most negative value and climbing in mixed strides: many duplicates,
        // small steps and large jumps.
        running = longint'(VALUE_MIN) + $urandom_range(0, 3);
        for (i = 0; i < DEPTH; i++)
        begin
            if (running > longint'(VALUE_MAX))
                running = VALUE_MAX;
            item.mode  = MODE_LOAD;
            item.index = POS_W'(i);
            item.value = running[VALUE_W-1:0];
            send_item(item, 1'b0, NO_HIT);
            pick = $urandom_range(0, 3);
            if (pick == 1)
                running += $urandom_range(1, 3);
            else if (pick == 2)
                running += $urandom_range(1, 1000);
            else if (pick == 3)
                running += $urandom_range(1, 16000000);
        end
        drain_responses();

        // Random phases. Each one sets a new element_count, repairs the order
        // of the searched entries, then runs mostly queries on the sorted
        // table mixed with order-keeping loads and some out-of-order noise.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            idle_mode = idle_mode_t'(phase % 4);
            case (idle_mode)
                IDLE_NONE:     begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
                IDLE_SENDER:   begin req_gap_pct = 77; rsp_stall_pct = 0;  end
                IDLE_RECEIVER: begin req_gap_pct = 0;  rsp_stall_pct = 77; end
                default:       begin req_gap_pct = 21; rsp_stall_pct = 21; end
            endcase

            count = phase_counts[phase];
            if (count < 0)
                count = (phase % 2 == 0) ? $urandom_range(3, 64) : $urandom_range(65, 1023);
            wdata = PDATA_W'(count);
            if ($urandom_range(0, 3) == 0)
                wdata = ($urandom & ~32'h7FF) | wdata;
            write_register(COUNT_ADDR, wdata);
            if ($urandom_range(0, 2) == 0)
                write_register(SPARE_ADDR, $urandom);
            n_eff = (count_mirror > DEPTH) ? DEPTH : int'(count_mirror);

            // Noise from the previous phase may have broken the order. One
            // forward pass that copies the left neighbor over any smaller
            // entry makes the searched range non-decreasing again.
            for (i = 1; i < n_eff; i++)
            begin
                if (entry_mirror[i] < entry_mirror[i-1])
                begin
                    item.mode  = MODE_LOAD;
                    item.index = POS_W'(i);
                    item.value = entry_mirror[i-1];
                    send_item(item, 1'b0, NO_HIT);
                end
            end

            // In the first phase the receiver holds off for a long time while
            // the sender keeps going, so the output register fills and the
            // block has to stall incoming queries.
            if (phase == 0)
                rsp_hold_left = HOLD_CYCLES;

            repeat (PHASE_ITEMS)
            begin
                item.index = POS_W'($urandom);
                item.value = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    item.mode = MODE_QUERY;
                    idx = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
                    pick = $urandom_range(0, 99);
                    if (n_eff > 0 && pick < 60)
                        item.value = entry_mirror[idx];
                    else if (n_eff > 0 && pick < 85)
                        item.value = entry_mirror[idx] + (($urandom_range(0, 1) == 1) ? 1 : -1);
                    else if (pick < 93)
                        item.value = ($urandom_range(0, 1) == 1) ? VALUE_MAX : VALUE_MIN;
                end
                else if (pick < 90)
                begin
                    // Order-keeping load: the new value lies between the
                    // neighbors, often equal to one of them.
                    item.mode = MODE_LOAD;
                    idx = $urandom_range(0, ((n_eff > 0) ? n_eff : DEPTH) - 1);
                    left  = (idx > 0) ? longint'(entry_mirror[idx-1]) : longint'(VALUE_MIN);
                    right = (idx < DEPTH - 1) ? longint'(entry_mirror[idx+1])
                                              : longint'(VALUE_MAX);
                    if (right < left)
                        right = left;
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        running = left;
                    else if (pick == 1)
                        running = right;
                    else
                    begin
                        wide_rand = {$urandom, $urandom};
                        running = left + longint'(wide_rand % unsigned'(right - left + 1));
                    end
                    item.index = POS_W'(idx);
                    item.value = running[VALUE_W-1:0];
                end
                else
                begin
                    // Noise load: random index and value, order not kept.
                    item.mode = MODE_LOAD;
                end
                send_item(item, 1'b0, NO_HIT);
            end
            drain_responses();
        end

        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
